// ===== rtl/core/assert_macros.svh =====
// Assertion macros, included by the codec top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check, active during reset too.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/mimc_pkg.sv =====
// Shared constants, types and digit arithmetic for the MIN codec.
package mimc_pkg;

  localparam int unsigned NumW      = 34;
  localparam int unsigned Min1W     = 24;
  localparam int unsigned Min2W     = 10;
  localparam int unsigned Min2InW   = 16;
  localparam int unsigned GrpW      = 10;
  localparam int unsigned ThouW     = 4;
  localparam int unsigned DigW      = 4;
  localparam int unsigned NumGroups = 3;
  localparam int unsigned HiShift   = 14;
  localparam int unsigned ThouShift = 10;
  localparam int unsigned NumStages = 4;

  localparam logic [NumW-1:0] NumMax = 34'd9999999999;

  // cmd codes
  localparam logic CmdEncode = 1'b0;
  localparam logic CmdDecode = 1'b1;

  // Group indexes: low, middle, high
  localparam int unsigned GrpLo  = 0;
  localparam int unsigned GrpMid = 1;
  localparam int unsigned GrpHi  = 2;

  // Reciprocals for exact division by constants (rounded up, shift = width + log2 d)
  localparam logic [27:0] RecipE7   = 28'((45'd1 << 44) / 45'd78125 + 45'd1);
  localparam logic [30:0] RecipE4   = 31'((41'd1 << 40) / 41'd625 + 41'd1);
  localparam logic [31:0] RecipE3   = 32'((39'd1 << 38) / 39'd125 + 39'd1);
  localparam logic [16:0] Recip10   = 17'((21'd1 << 20) / 21'd10 + 21'd1);
  localparam logic [16:0] Recip100  = 17'((24'd1 << 23) / 24'd100 + 24'd1);
  localparam logic [16:0] Recip1000 = 17'((27'd1 << 26) / 27'd1000 + 27'd1);

  typedef struct packed {
    logic [NumStages-1:0] load;   // per-stage register enable
    logic                 cmd_c;  // cmd of the item in the last internal stage
  } mimc_ctrl_t;

  // n / 10^7, n >> 7 then / 78125
  function automatic logic [10:0] div_e7(input logic [NumW-1:0] n);
    logic [54:0] p;
    p = 55'(n[33:7]) * 55'(RecipE7);
    return p[54:44];
  endfunction

  // n / 10^4, n >> 4 then / 625
  function automatic logic [20:0] div_e4(input logic [NumW-1:0] n);
    logic [60:0] p;
    p = 61'(n[33:4]) * 61'(RecipE4);
    return p[60:40];
  endfunction

  // n / 10^3, n >> 3 then / 125
  function automatic logic [24:0] div_e3(input logic [NumW-1:0] n);
    logic [62:0] p;
    p = 63'(n[33:3]) * 63'(RecipE3);
    return p[62:38];
  endfunction

  function automatic logic [12:0] div10(input logic [15:0] v);
    logic [32:0] p;
    p = 33'(v) * 33'(Recip10);
    return p[32:20];
  endfunction

  function automatic logic [9:0] div100(input logic [15:0] v);
    logic [32:0] p;
    p = 33'(v) * 33'(Recip100);
    return p[32:23];
  endfunction

  function automatic logic [6:0] div1000(input logic [15:0] v);
    logic [32:0] p;
    p = 33'(v) * 33'(Recip1000);
    return p[32:26];
  endfunction

  // a - 10*b, modulo 16; a digit when b = a / 10
  function automatic logic [DigW-1:0] low_digit(input logic [DigW-1:0] a,
                                                input logic [DigW-1:0] b);
    return a - (b << 3) - (b << 1);
  endfunction

  // (d + 9) mod 10
  function automatic logic [DigW-1:0] enc_digit(input logic [DigW-1:0] d);
    return (d == '0) ? 4'd9 : d - 4'd1;
  endfunction

  // (d + 1) mod 10
  function automatic logic [DigW-1:0] dec_digit(input logic [DigW-1:0] d);
    return (d == 4'd9) ? 4'd0 : d + 4'd1;
  endfunction

  function automatic logic [GrpW-1:0] group_value(input logic [DigW-1:0] d2,
                                                  input logic [DigW-1:0] d1,
                                                  input logic [DigW-1:0] d0);
    return 10'(d2) * 10'd100 + 10'(d1) * 10'd10 + 10'(d0);
  endfunction

endpackage

// ===== rtl/core/mobile_id_min_codec_unit.sv =====
// Top level of the MIN1/MIN2 codec: stream ports, pipeline and output register.
// An accepted item lands in the first of three datapath stages at accept, then
// passes the other two and the output register before the result is valid.
// Throughput: one item per cycle while the output is not stalled, any mix of
// cmds; the four-stage pipeline stalls in place and accepts a new item whenever
// some stage has room. Reset (rst_ni low, asynchronous) clears all stage valid
// bits; data registers are not reset. No state survives between items.
module mobile_id_min_codec_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // number_in[33:0], min1_in[65:34], min2_in[81:66], pad
  input  logic [0:0]  s_axis_tuser,  // cmd[0]
  // result item
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // number_out[33:0], min1_out[57:34], min2_out[67:58], pad
  output logic [0:0]  m_axis_tuser   // range_error[0]
);

  `include "assert_macros.svh"

  // Unpacked input fields
  logic [mimc_pkg::NumW-1:0]    in_number;
  logic [31:0]                  in_min1;
  logic [mimc_pkg::Min2InW-1:0] in_min2;

  assign in_number = s_axis_tdata[33:0];
  assign in_min1   = s_axis_tdata[65:34];
  assign in_min2   = s_axis_tdata[81:66];

  mimc_pkg::mimc_ctrl_t ctrl;

  // Handshake and per-stage valid bits; load[3] enables the output register
  mimc_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_cmd_i    (s_axis_tuser[0]),
    .out_ready_i (m_axis_tready),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .ctrl_o      (ctrl)
  );

  logic [mimc_pkg::Min1W-1:0] enc_min1;
  logic [mimc_pkg::Min2W-1:0] enc_min2;
  logic                       enc_err;
  logic [mimc_pkg::NumW-1:0]  dec_number;

  // Both paths see every item; the cmd tag picks the result at the end
  mimc_enc_path u_enc (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .number_i (in_number),
    .min1_o   (enc_min1),
    .min2_o   (enc_min2),
    .err_o    (enc_err)
  );

  // Only MIN1 bits 23..0 carry fields
  mimc_dec_path u_dec (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .min1_i   (in_min1[mimc_pkg::Min1W-1:0]),
    .min2_i   (in_min2),
    .number_o (dec_number)
  );

  // Output register: fields of the unused direction read as zero
  logic [mimc_pkg::NumW-1:0]  out_number_q, out_number_d;
  logic [mimc_pkg::Min1W-1:0] out_min1_q, out_min1_d;
  logic [mimc_pkg::Min2W-1:0] out_min2_q, out_min2_d;
  logic                       out_err_q, out_err_d;

  always_comb begin
    if (ctrl.cmd_c == mimc_pkg::CmdDecode) begin
      out_number_d = dec_number;
      out_min1_d   = '0;
      out_min2_d   = '0;
      out_err_d    = 1'b0;
    end else begin
      out_number_d = '0;
      out_min1_d   = enc_min1;
      out_min2_d   = enc_min2;
      out_err_d    = enc_err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load[mimc_pkg::NumStages-1]) begin
      out_number_q <= out_number_d;
      out_min1_q   <= out_min1_d;
      out_min2_q   <= out_min2_d;
      out_err_q    <= out_err_d;
    end
  end

  assign m_axis_tdata = {4'b0000, out_min2_q, out_min1_q, out_number_q};
  assign m_axis_tuser = out_err_q;

  // Checks
  `ASSERT_CLK(a_mode_excl, m_axis_tvalid && (out_number_q != '0) |-> (out_min1_q == '0) && (out_min2_q == '0) && !out_err_q, "decoded item carries encode fields")
  `ASSERT_CLK(a_err_zero, m_axis_tvalid && out_err_q |-> (out_min1_q == '0) && (out_min2_q == '0), "range error with nonzero words")
  `ASSERT_CLK(a_num_range, m_axis_tvalid |-> out_number_q <= mimc_pkg::NumMax, "decoded number above ten digits")
  `ASSERT_CLK(a_stall_only, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input held off without output stall")
  `ASSERT_ALWAYS(a_rst_idle, !rst_ni |-> !m_axis_tvalid, "result valid during reset")

endmodule

// ===== rtl/core/mimc_pipe_ctrl.sv =====
// Valid tracking and stall control for the codec pipeline.
module mimc_pipe_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_cmd_i,
  input  logic                 out_ready_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  output mimc_pkg::mimc_ctrl_t ctrl_o
);

  localparam int unsigned NS = mimc_pkg::NumStages;

  logic [NS-1:0] valid_q, valid_d;
  logic [NS-1:0] ready;
  logic [NS-2:0] cmd_q, cmd_d;

  // A stage takes new data when empty or when the next one takes its item
  always_comb begin
    ready[NS-1] = !valid_q[NS-1] || out_ready_i;
    for (int i = NS - 2; i >= 0; i--) begin
      ready[i] = !valid_q[i] || ready[i+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (ready[0]) begin
      valid_d[0] = in_valid_i;
      cmd_d[0]   = in_cmd_i;
    end
    for (int i = 1; i < NS; i++) begin
      if (ready[i]) begin
        valid_d[i] = valid_q[i-1];
      end
    end
    for (int i = 1; i < NS - 1; i++) begin
      if (ready[i]) begin
        cmd_d[i] = cmd_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      cmd_q   <= '0;
    end else begin
      valid_q <= valid_d;
      cmd_q   <= cmd_d;
    end
  end

  assign in_ready_o   = ready[0];
  assign out_valid_o  = valid_q[NS-1];
  assign ctrl_o.load  = ready;
  assign ctrl_o.cmd_c = cmd_q[NS-2];

endmodule

// ===== rtl/core/mimc_enc_path.sv =====
// Encode datapath: number to MIN1/MIN2, three register stages.
module mimc_enc_path (
  input  logic                            clk_i,
  input  mimc_pkg::mimc_ctrl_t            ctrl_i,
  input  logic [mimc_pkg::NumW-1:0]       number_i,
  output logic [mimc_pkg::Min1W-1:0]      min1_o,
  output logic [mimc_pkg::Min2W-1:0]      min2_o,
  output logic                            err_o
);

  localparam int unsigned GW = mimc_pkg::GrpW;
  localparam int unsigned DW = mimc_pkg::DigW;
  localparam int unsigned NG = mimc_pkg::NumGroups;

  // Stage A: decimal quotients of the number (low bits only are needed)
  logic [GW-1:0] a_n_q, a_n_d;
  logic [GW-1:0] a_q7_q, a_q7_d;
  logic [GW-1:0] a_q4_q, a_q4_d;
  logic [GW-1:0] a_q3_q, a_q3_d;
  logic          a_err_q, a_err_d;

  logic [10:0] q7_full;
  logic [20:0] q4_full;
  logic [24:0] q3_full;

  always_comb begin
    q7_full = mimc_pkg::div_e7(number_i);
    q4_full = mimc_pkg::div_e4(number_i);
    q3_full = mimc_pkg::div_e3(number_i);
    a_n_d   = number_i[GW-1:0];
    a_q7_d  = q7_full[GW-1:0];
    a_q4_d  = q4_full[GW-1:0];
    a_q3_d  = q3_full[GW-1:0];
    a_err_d = number_i > mimc_pkg::NumMax;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[0]) begin
      a_n_q   <= a_n_d;
      a_q7_q  <= a_q7_d;
      a_q4_q  <= a_q4_d;
      a_q3_q  <= a_q3_d;
      a_err_q <= a_err_d;
    end
  end

  // Stage B: groups and thousands digit, remainders taken modulo 2^width
  logic [NG-1:0][GW-1:0] b_grp_q, b_grp_d;
  logic [DW-1:0]         b_th_q, b_th_d;
  logic                  b_err_q;

  always_comb begin
    b_grp_d[mimc_pkg::GrpHi]  = a_q7_q;
    b_grp_d[mimc_pkg::GrpMid] = a_q4_q - a_q7_q * 10'd1000;
    b_grp_d[mimc_pkg::GrpLo]  = a_n_q - a_q3_q * 10'd1000;
    b_th_d = mimc_pkg::low_digit(a_q3_q[DW-1:0], a_q4_q[DW-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[1]) begin
      b_grp_q <= b_grp_d;
      b_th_q  <= b_th_d;
      b_err_q <= a_err_q;
    end
  end

  // Stage C: per-group quotients by 10 and 100
  logic [NG-1:0][DW-1:0] c_g_q, c_g_d;
  logic [NG-1:0][DW-1:0] c_q10_q, c_q10_d;
  logic [NG-1:0][DW-1:0] c_q100_q, c_q100_d;
  logic [DW-1:0]         c_th_q;
  logic                  c_err_q;
  logic [NG-1:0][12:0]   q10_full;
  logic [NG-1:0][9:0]    q100_full;

  always_comb begin
    for (int k = 0; k < NG; k++) begin
      q10_full[k]  = mimc_pkg::div10(16'(b_grp_q[k]));
      q100_full[k] = mimc_pkg::div100(16'(b_grp_q[k]));
      c_g_d[k]     = b_grp_q[k][DW-1:0];
      c_q10_d[k]   = q10_full[k][DW-1:0];
      c_q100_d[k]  = q100_full[k][DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[2]) begin
      c_g_q    <= c_g_d;
      c_q10_q  <= c_q10_d;
      c_q100_q <= c_q100_d;
      c_th_q   <= b_th_q;
      c_err_q  <= b_err_q;
    end
  end

  // Final digit mapping and packing, registered by the top level
  logic [NG-1:0][GW-1:0] enc_grp;
  logic [DW-1:0]         thou;

  always_comb begin
    for (int k = 0; k < NG; k++) begin
      enc_grp[k] = mimc_pkg::group_value(
                     mimc_pkg::enc_digit(c_q100_q[k]),
                     mimc_pkg::enc_digit(mimc_pkg::low_digit(c_q10_q[k], c_q100_q[k])),
                     mimc_pkg::enc_digit(mimc_pkg::low_digit(c_g_q[k], c_q10_q[k])));
    end
    // thousands digit zero is sent as ten
    thou = (c_th_q == '0) ? 4'd10 : c_th_q;
    if (c_err_q) begin
      min1_o = '0;
      min2_o = '0;
    end else begin
      min1_o = {enc_grp[mimc_pkg::GrpMid], thou, enc_grp[mimc_pkg::GrpLo]};
      min2_o = enc_grp[mimc_pkg::GrpHi];
    end
    err_o = c_err_q;
  end

endmodule

// ===== rtl/core/mimc_dec_path.sv =====
// Decode datapath: MIN1/MIN2 to number, three register stages.
module mimc_dec_path (
  input  logic                            clk_i,
  input  mimc_pkg::mimc_ctrl_t            ctrl_i,
  input  logic [mimc_pkg::Min1W-1:0]      min1_i,
  input  logic [mimc_pkg::Min2InW-1:0]    min2_i,
  output logic [mimc_pkg::NumW-1:0]       number_o
);

  localparam int unsigned GW = mimc_pkg::GrpW;
  localparam int unsigned DW = mimc_pkg::DigW;
  localparam int unsigned NG = mimc_pkg::NumGroups;

  // Stage A: quotients by 10, 100, 1000 of each raw field (low nibbles kept)
  logic [NG-1:0][15:0]   fld;
  logic [NG-1:0][12:0]   q10_full;
  logic [NG-1:0][9:0]    q100_full;
  logic [NG-1:0][6:0]    q1000_full;
  logic [NG-1:0][DW-1:0] a_v_q, a_v_d;
  logic [NG-1:0][DW-1:0] a_q10_q, a_q10_d;
  logic [NG-1:0][DW-1:0] a_q100_q, a_q100_d;
  logic [NG-1:0][DW-1:0] a_q1000_q, a_q1000_d;
  logic [mimc_pkg::ThouW-1:0] a_th_q;

  always_comb begin
    fld[mimc_pkg::GrpLo]  = 16'(min1_i[GW-1:0]);
    fld[mimc_pkg::GrpMid] = 16'(min1_i[mimc_pkg::HiShift +: GW]);
    fld[mimc_pkg::GrpHi]  = min2_i;
    for (int k = 0; k < NG; k++) begin
      q10_full[k]   = mimc_pkg::div10(fld[k]);
      q100_full[k]  = mimc_pkg::div100(fld[k]);
      q1000_full[k] = mimc_pkg::div1000(fld[k]);
      a_v_d[k]      = fld[k][DW-1:0];
      a_q10_d[k]    = q10_full[k][DW-1:0];
      a_q100_d[k]   = q100_full[k][DW-1:0];
      a_q1000_d[k]  = q1000_full[k][DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[0]) begin
      a_v_q     <= a_v_d;
      a_q10_q   <= a_q10_d;
      a_q100_q  <= a_q100_d;
      a_q1000_q <= a_q1000_d;
      a_th_q    <= min1_i[mimc_pkg::ThouShift +: mimc_pkg::ThouW];
    end
  end

  // Stage B: digits plus one modulo ten, groups rebuilt below 1000
  logic [NG-1:0][GW-1:0] b_grp_q, b_grp_d;
  logic [DW-1:0]         b_th_q, b_th_d;

  always_comb begin
    for (int k = 0; k < NG; k++) begin
      b_grp_d[k] = mimc_pkg::group_value(
                     mimc_pkg::dec_digit(mimc_pkg::low_digit(a_q100_q[k], a_q1000_q[k])),
                     mimc_pkg::dec_digit(mimc_pkg::low_digit(a_q10_q[k], a_q100_q[k])),
                     mimc_pkg::dec_digit(mimc_pkg::low_digit(a_v_q[k], a_q10_q[k])));
    end
    // thousands field of ten or more wraps
    b_th_d = (a_th_q >= 4'd10) ? a_th_q - 4'd10 : a_th_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[1]) begin
      b_grp_q <= b_grp_d;
      b_th_q  <= b_th_d;
    end
  end

  // Stage C: weighted parts of the number
  logic [mimc_pkg::NumW-1:0] c_hi_q, c_hi_d;
  logic [23:0]               c_mid_q, c_mid_d;
  logic [13:0]               c_lo_q, c_lo_d;

  always_comb begin
    c_hi_d  = 34'(b_grp_q[mimc_pkg::GrpHi]) * 34'd10000000;
    c_mid_d = 24'(b_grp_q[mimc_pkg::GrpMid]) * 24'd10000;
    c_lo_d  = 14'(b_th_q) * 14'd1000 + 14'(b_grp_q[mimc_pkg::GrpLo]);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[2]) begin
      c_hi_q  <= c_hi_d;
      c_mid_q <= c_mid_d;
      c_lo_q  <= c_lo_d;
    end
  end

  assign number_o = c_hi_q + 34'(c_mid_q) + 34'(c_lo_q);

endmodule

// ===== test/min_codec_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the MIN codec: predicts each result from accepted items and compares.
module min_codec_checker
  import mimc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,
  input  logic [0:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,
  input  logic [0:0]  m_axis_tuser,
  output int          errors_o,
  output int          pending_o
);

  typedef struct {
    logic [NumW-1:0]  number;
    logic [Min1W-1:0] min1;
    logic [Min2W-1:0] min2;
    logic             range_err;
  } min_result_t;

  min_result_t expected_words_q[$];
  min_result_t want;
  int          fail_count = 0;
  int          waiting    = 0;

  assign errors_o  = fail_count;
  assign pending_o = waiting;

  // Adds step to each decimal digit of a group, mod 10; the hundreds digit
  // is v/100, so fields of 1000 and up still land below 1000.
  function automatic int unsigned shift_digits(int unsigned v, int unsigned step);
    return (v % 10 + step) % 10
         + ((v % 100) / 10 + step) % 10 * 10
         + (v / 100 + step) % 10 * 100;
  endfunction

  function automatic min_result_t predict_conversion(logic cmd, logic [NumW-1:0] num,
                                                     logic [31:0] m1, logic [15:0] m2);
    min_result_t      r;
    longint unsigned  n;
    int unsigned      hi, mid, th, lo;
    r = '{default: '0};
    if (cmd == CmdEncode) begin
      n = num;
      if (num > NumMax) begin
        r.range_err = 1'b1;
      end else begin
        lo  = n % 1000;
        th  = (n / 1000) % 10;
        mid = (n / 10000) % 1000;
        hi  = n / 10000000;
        if (th == 0) th = 10;
        r.min1 = Min1W'((shift_digits(mid, 9) << HiShift) | (th << ThouShift)
                        | shift_digits(lo, 9));
        r.min2 = Min2W'(shift_digits(hi, 9));
      end
    end else begin
      hi  = shift_digits(m2, 1);
      mid = shift_digits(m1[23:14], 1);
      th  = m1[13:10] % 10;
      lo  = shift_digits(m1[9:0], 1);
      r.number = NumW'(64'(hi) * 64'd10000000 + 64'(mid) * 64'd10000
                       + 64'(th) * 64'd1000 + 64'(lo));
    end
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned got_v);
    if (exp_v != got_v) begin
      fail_count++;
      $display("%0t: bad %s, expected %0h, got %0h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_words_q.delete();
      waiting = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words_q.size() == 0) begin
          fail_count++;
          $display("%0t: result item with nothing expected, expected none, got %0h/%0h",
                   $time, m_axis_tdata, m_axis_tuser);
        end else begin
          want = expected_words_q.pop_front();
          check_field("number_out",  want.number,    m_axis_tdata[33:0]);
          check_field("min1_out",    want.min1,      m_axis_tdata[57:34]);
          check_field("min2_out",    want.min2,      m_axis_tdata[67:58]);
          check_field("range_error", want.range_err, m_axis_tuser[0]);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_words_q.push_back(predict_conversion(s_axis_tuser[0], s_axis_tdata[33:0],
                                                      s_axis_tdata[65:34],
                                                      s_axis_tdata[81:66]));
      waiting = expected_words_q.size();
    end
  end

endmodule

// ===== test/mobile_id_min_codec_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the MIN codec: stimulus, stalls and the final verdict.
module mobile_id_min_codec_unit_tb;
  import mimc_pkg::*;

  localparam int RandomItems = 800;
  localparam int QuietTail   = 100;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;   // number_in[33:0], min1_in[65:34], min2_in[81:66], pad
  logic [0:0]  s_axis_tuser;   // cmd[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // number_out[33:0], min1_out[57:34], min2_out[67:58], pad
  logic [0:0]  m_axis_tuser;   // range_error[0]

  int errors;
  int pending;
  int idle_pct   = 30;   // chance in percent that a burst of idling starts
  int ready_hold = 0;
  int n_encode   = 0;
  int n_decode   = 0;
  int n_range    = 0;

  mobile_id_min_codec_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  min_codec_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side backpressure: random stall bursts, none while idle_pct is 0.
  always @(posedge clk_i) begin
    if (ready_hold > 0)
      ready_hold--;
    else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
      ready_hold = $urandom_range(1, 18);
    m_axis_tready <= (ready_hold == 0);
  end

  // Drive one item, with an optional idle burst ahead of it; returns once accepted.
  task automatic send_item(input logic cmd, input logic [NumW-1:0] num,
                           input logic [31:0] m1, input logic [15:0] m2);
    int gap;
    gap = 0;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, m2, m1, num};
    s_axis_tuser  <= cmd;
    if (cmd == CmdDecode) n_decode++;
    else if (num > NumMax) n_range++;
    else n_encode++;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_random();
    int              kind;
    int              d;
    longint unsigned n;
    logic [31:0]     m1;
    logic [15:0]     m2;
    kind = $urandom_range(0, 9);
    n    = {$urandom, $urandom};
    m1   = $urandom;
    m2   = 16'($urandom);
    if (kind <= 1) begin
      // uniform legal number
      send_item(CmdEncode, NumW'(n % 64'd10000000000), m1, m2);
    end else if (kind <= 3) begin
      // digit by digit, leaning on 0 and 9 so zero thousands digits show up often
      n = 0;
      for (int i = 0; i < 10; i++) begin
        d = $urandom_range(0, 9);
        if ($urandom_range(0, 2) == 0) d = $urandom_range(0, 1) ? 9 : 0;
        n = n * 10 + d;
      end
      send_item(CmdEncode, NumW'(n), m1, m2);
    end else if (kind == 4) begin
      // beyond ten digits
      send_item(CmdEncode, NumW'(64'd10000000000 + n % 64'd7179869184), m1, m2);
    end else if (kind <= 7) begin
      // words as an encoder would produce them, junk in the unused upper byte
      m1 = {m1[31:24], 10'($urandom_range(0, 999)), 4'($urandom_range(1, 10)),
            10'($urandom_range(0, 999))};
      m2 = 16'($urandom_range(0, 999));
      send_item(CmdDecode, NumW'(n), m1, m2);
    end else begin
      send_item(CmdDecode, NumW'(n), m1, m2);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    m_axis_tready <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, both commands, zero thousands digit, the
    // range limit, decode fields of 1000 and up and thousands fields past 9.
    send_item(CmdEncode, 34'd0,           '1, '1);
    send_item(CmdEncode, 34'd9999999999,  '0, '0);
    send_item(CmdEncode, 34'd10000000000, '0, '0);
    send_item(CmdEncode, '1,              '0, '0);
    send_item(CmdEncode, 34'd1234567890,  '0, '0);
    send_item(CmdEncode, 34'd5555505555,  '0, '0);
    send_item(CmdEncode, 34'd1000,        '0, '0);
    send_item(CmdEncode, 34'd9999990999,  '0, '0);
    send_item(CmdDecode, '0, 32'd0, 16'd0);
    send_item(CmdDecode, '1, '1, '1);
    send_item(CmdDecode, '0, {8'h00, 10'd999, 4'd10, 10'd999}, 16'd999);
    send_item(CmdDecode, '0, {8'h00, 10'd1000, 4'd15, 10'd1023}, 16'd1000);
    send_item(CmdDecode, '0, {8'hA5, 10'd1023, 4'd0, 10'd1000}, 16'd65535);
    send_item(CmdDecode, '0, {8'h00, 10'd123, 4'd9, 10'd456}, 16'd789);
    send_item(CmdDecode, '0, {8'h00, 10'd0, 4'd11, 10'd0}, 16'd32768);
    send_item(CmdDecode, '0, {8'hFF, 10'd512, 4'd1, 10'd1}, 16'd1999);

    for (int i = 0; i < RandomItems; i++) begin
      if (i == RandomItems - QuietTail) begin
        idle_pct <= 0;
      end else if (i % 80 == 0 && i < RandomItems - QuietTail) begin
        case ($urandom_range(0, 3))
          0: idle_pct <= 0;
          1: idle_pct <= 15;
          2: idle_pct <= 40;
          default: idle_pct <= 70;
        endcase
      end
      send_random();
    end
    s_axis_tvalid <= 1'b0;

    do @(negedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d legal encodes, %0d out-of-range encodes and %0d decodes,",
             n_encode, n_range, n_decode);
    $display("with random idle bursts on both streams and a stall-free tail.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
